[rtl/mqsb_pkg.sv]
package mqsb_pkg;

  localparam int unsigned FuncW   = 1;
  localparam int unsigned QidW    = 2;
  localparam int unsigned WordW   = 32;
  localparam int unsigned StatusW = 2;

  localparam logic [FuncW-1:0] FuncEnq = 1'b0;
  localparam logic [FuncW-1:0] FuncDeq = 1'b1;

  localparam logic [StatusW-1:0] StatusOk    = 2'd0;
  localparam logic [StatusW-1:0] StatusFull  = 2'd1;
  localparam logic [StatusW-1:0] StatusEmpty = 2'd2;

endpackage

[rtl/mqsb_slot_store.sv]
module mqsb_slot_store #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [$clog2(SLOTS+1)-1:0]        fill_i,
  input  logic                              rd_en_i,
  input  logic [$clog2(SLOTS+1)-1:0]        rd_addr_i,
  output logic [$clog2(SLOTS+1)-1:0]        rd_link_o,
  output logic [mqsb_pkg::WordW-1:0]        rd_data_o,
  input  logic                              link_we_i,
  input  logic [$clog2(SLOTS+1)-1:0]        link_addr_i,
  input  logic [$clog2(SLOTS+1)-1:0]        link_data_i,
  input  logic                              data_we_i,
  input  logic [$clog2(SLOTS+1)-1:0]        data_addr_i,
  input  logic [mqsb_pkg::WordW-1:0]        data_data_i
);

  localparam int unsigned PW = $clog2(SLOTS + 1);
  localparam int unsigned AW = $clog2(SLOTS);

  logic [PW-1:0]              link_mem [SLOTS];
  logic [mqsb_pkg::WordW-1:0] data_mem [SLOTS];

  logic [PW-1:0]              link_q;
  logic [mqsb_pkg::WordW-1:0] data_q;
  logic [PW-1:0]              addr_q;
  logic                       fresh_q;

  // slots at or above the fill mark still hold the reset chain
  always_ff @(posedge clk_i) begin
    if (link_we_i) begin
      link_mem[link_addr_i[AW-1:0]] <= link_data_i;
    end
    if (data_we_i) begin
      data_mem[data_addr_i[AW-1:0]] <= data_data_i;
    end
    if (rd_en_i) begin
      link_q <= link_mem[rd_addr_i[AW-1:0]];
      data_q <= data_mem[rd_addr_i[AW-1:0]];
      addr_q <= rd_addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q <= 1'b0;
    end else if (rd_en_i) begin
      fresh_q <= (rd_addr_i >= fill_i);
    end
  end

  assign rd_link_o = fresh_q ? PW'(addr_q + 1'b1) : link_q;
  assign rd_data_o = data_q;

endmodule

[rtl/mqsb_queue_table.sv]
module mqsb_queue_table #(
  parameter int unsigned SLOTS  = 16,
  parameter int unsigned QUEUES = 4
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         rd_en_i,
  input  logic [((QUEUES > 1) ? $clog2(QUEUES) : 1)-1:0] rd_addr_i,
  output logic [$clog2(SLOTS+1)-1:0]                   rd_head_o,
  output logic [$clog2(SLOTS+1)-1:0]                   rd_tail_o,
  input  logic                                         we_i,
  input  logic [((QUEUES > 1) ? $clog2(QUEUES) : 1)-1:0] wr_addr_i,
  input  logic [$clog2(SLOTS+1)-1:0]                   wr_head_i,
  input  logic [$clog2(SLOTS+1)-1:0]                   wr_tail_i
);

  localparam int unsigned PW = $clog2(SLOTS + 1);
  localparam logic [PW-1:0] PtrNull = PW'(SLOTS);

  logic [PW-1:0]     head_mem [QUEUES];
  logic [PW-1:0]     tail_mem [QUEUES];
  logic [QUEUES-1:0] valid_q;
  logic              rd_valid_q;
  logic [PW-1:0]     head_q;
  logic [PW-1:0]     tail_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      head_mem[wr_addr_i] <= wr_head_i;
      tail_mem[wr_addr_i] <= wr_tail_i;
    end
    if (rd_en_i) begin
      head_q <= head_mem[rd_addr_i];
      tail_q <= tail_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  // an unwritten queue reads as empty
  assign rd_head_o = rd_valid_q ? head_q : PtrNull;
  assign rd_tail_o = rd_valid_q ? tail_q : PtrNull;

endmodule

[rtl/multi_queue_shared_buffer.sv]
// Result: done_o is registered from StLook for an enqueue or any request that fails,
// and from StDeq, which follows StLook, for a successful dequeue.
// Flow: a new request is taken only back in StIdle, never before the last one is done, due to
// the read-then-write of the queue table and slot store, each with a registered read.
// Reset: asynchronous, active low; all queues empty, free list is the chain of all slots.
// The receiver cannot stall: done_o marks a result for exactly one cycle.
module multi_queue_shared_buffer #(
  parameter int unsigned SLOTS  = 16,
  parameter int unsigned QUEUES = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [mqsb_pkg::FuncW-1:0]          func_i,
  input  logic [mqsb_pkg::QidW-1:0]           queue_id_i,
  input  logic signed [mqsb_pkg::WordW-1:0]   value_i,
  output logic                                done_o,
  output logic [mqsb_pkg::StatusW-1:0]        status_o,
  output logic signed [mqsb_pkg::WordW-1:0]   data_o
);

  localparam int unsigned PW = $clog2(SLOTS + 1);
  localparam int unsigned QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam logic [PW-1:0] PtrNull = PW'(SLOTS);
  localparam logic [mqsb_pkg::QidW-1:0] QueuesLow = QUEUES[mqsb_pkg::QidW-1:0];

  typedef enum logic [1:0] {
    StIdle,
    StLook,
    StDeq
  } state_e;

  state_e                        state_q;
  logic [mqsb_pkg::FuncW-1:0]    func_q;
  logic [QW-1:0]                 qid_q;
  logic [mqsb_pkg::WordW-1:0]    value_q;
  logic [PW-1:0]                 free_head_q;
  logic [PW-1:0]                 fill_q;
  logic [PW-1:0]                 cur_head_q;
  logic [PW-1:0]                 cur_tail_q;
  logic                          done_q;
  logic [mqsb_pkg::StatusW-1:0]  status_q;
  logic [mqsb_pkg::WordW-1:0]    data_q;

  logic                          accept;
  logic [mqsb_pkg::QidW-1:0]     qid_wrap;
  logic [QW-1:0]                 qidx;
  logic [PW-1:0]                 qt_head;
  logic [PW-1:0]                 qt_tail;
  logic                          qt_we;
  logic [PW-1:0]                 qt_wr_head;
  logic [PW-1:0]                 qt_wr_tail;
  logic                          slot_rd_en;
  logic [PW-1:0]                 slot_rd_addr;
  logic [PW-1:0]                 slot_link;
  logic [mqsb_pkg::WordW-1:0]    slot_data;
  logic                          link_we;
  logic [PW-1:0]                 link_addr;
  logic [PW-1:0]                 link_data;
  logic                          data_we;
  logic                          enq_ok;
  logic                          deq_ok;
  logic [PW-1:0]                 new_head;

  always_comb begin
    qid_wrap = queue_id_i;
    for (int i = 0; i < (1 << mqsb_pkg::QidW) - 1; i++) begin
      if (32'(qid_wrap) >= QUEUES) begin
        qid_wrap = qid_wrap - QueuesLow;
      end
    end
  end

  assign accept = start_i && (state_q == StIdle);
  assign qidx   = QW'(qid_wrap);
  assign enq_ok = (state_q == StLook) && (func_q == mqsb_pkg::FuncEnq)
                  && (free_head_q != PtrNull);
  assign deq_ok = (state_q == StLook) && (func_q == mqsb_pkg::FuncDeq)
                  && (qt_head != PtrNull);
  assign new_head = (cur_head_q == cur_tail_q) ? PtrNull : slot_link;

  always_comb begin
    slot_rd_en   = 1'b0;
    slot_rd_addr = free_head_q;
    qt_we        = 1'b0;
    qt_wr_head   = qt_head;
    qt_wr_tail   = free_head_q;
    link_we      = 1'b0;
    link_addr    = qt_tail;
    link_data    = free_head_q;
    data_we      = 1'b0;
    if (accept) begin
      slot_rd_en = 1'b1;
    end
    if (enq_ok) begin
      qt_we      = 1'b1;
      qt_wr_head = (qt_head == PtrNull) ? free_head_q : qt_head;
      data_we    = 1'b1;
      link_we    = (qt_head != PtrNull);
    end
    if (deq_ok) begin
      slot_rd_en   = 1'b1;
      slot_rd_addr = qt_head;
    end
    if (state_q == StDeq) begin
      qt_we      = 1'b1;
      qt_wr_head = new_head;
      qt_wr_tail = cur_tail_q;
      link_we    = 1'b1;
      link_addr  = cur_head_q;
      link_data  = free_head_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      free_head_q <= '0;
      fill_q      <= '0;
      done_q      <= 1'b0;
      status_q    <= mqsb_pkg::StatusOk;
      data_q      <= '0;
      func_q      <= mqsb_pkg::FuncEnq;
      qid_q       <= '0;
      value_q     <= '0;
      cur_head_q  <= PtrNull;
      cur_tail_q  <= PtrNull;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (start_i) begin
            func_q  <= func_i;
            qid_q   <= qidx;
            value_q <= value_i;
            state_q <= StLook;
          end
        end
        StLook: begin
          if (func_q == mqsb_pkg::FuncEnq) begin
            done_q  <= 1'b1;
            data_q  <= '0;
            state_q <= StIdle;
            if (free_head_q == PtrNull) begin
              status_q <= mqsb_pkg::StatusFull;
            end else begin
              status_q    <= mqsb_pkg::StatusOk;
              free_head_q <= slot_link;
              if (free_head_q == fill_q) begin
                fill_q <= PW'(fill_q + 1'b1);
              end
            end
          end else if (qt_head == PtrNull) begin
            done_q   <= 1'b1;
            status_q <= mqsb_pkg::StatusEmpty;
            data_q   <= '0;
            state_q  <= StIdle;
          end else begin
            cur_head_q <= qt_head;
            cur_tail_q <= qt_tail;
            state_q    <= StDeq;
          end
        end
        StDeq: begin
          done_q      <= 1'b1;
          status_q    <= mqsb_pkg::StatusOk;
          data_q      <= slot_data;
          free_head_q <= cur_head_q;
          state_q     <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  mqsb_queue_table #(
    .SLOTS  (SLOTS),
    .QUEUES (QUEUES)
  ) u_queue_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (qidx),
    .rd_head_o (qt_head),
    .rd_tail_o (qt_tail),
    .we_i      (qt_we),
    .wr_addr_i (qid_q),
    .wr_head_i (qt_wr_head),
    .wr_tail_i (qt_wr_tail)
  );

  mqsb_slot_store #(
    .SLOTS (SLOTS)
  ) u_slot_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fill_i      (fill_q),
    .rd_en_i     (slot_rd_en),
    .rd_addr_i   (slot_rd_addr),
    .rd_link_o   (slot_link),
    .rd_data_o   (slot_data),
    .link_we_i   (link_we),
    .link_addr_i (link_addr),
    .link_data_i (link_data),
    .data_we_i   (data_we),
    .data_addr_i (free_head_q),
    .data_data_i (value_q)
  );

  assign busy_o   = (state_q != StIdle);
  assign done_o   = done_q;
  assign status_o = status_q;
  assign data_o   = data_q;

endmodule

[rtl/mqsb_checker.sv]
module mqsb_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start_i,
  input logic                               busy_o,
  input logic                               done_o,
  input logic [mqsb_pkg::StatusW-1:0]       status_o,
  input logic [mqsb_pkg::WordW-1:0]         data_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o && !done_o)
    else $error("accepted word did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while busy");

  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("request finished without a result");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == mqsb_pkg::StatusOk) || (status_o == mqsb_pkg::StatusFull)
               || (status_o == mqsb_pkg::StatusEmpty))
    else $error("bad status code");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != mqsb_pkg::StatusOk) |-> (data_o == '0))
    else $error("failed request returned data");

endmodule

bind multi_queue_shared_buffer mqsb_checker u_mqsb_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .done_o   (done_o),
  .status_o (status_o),
  .data_o   (data_o)
);

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int unsigned Slots     = 16;
  localparam int unsigned Queues    = 4;
  localparam int unsigned RandWords = 1800;
  localparam int unsigned IdleLimit = 2000;

  typedef logic [4:0] ptr_t;
  localparam ptr_t PtrNull = ptr_t'(Slots);

  typedef logic [mqsb_pkg::QidW-1:0] qid_t;

  typedef struct packed {
    logic [mqsb_pkg::StatusW-1:0]      status;
    logic signed [mqsb_pkg::WordW-1:0] data;
  } result_t;

  logic                                clk_i      = 1'b0;
  logic                                rst_ni     = 1'b0;
  logic                                start_i    = 1'b0;
  logic [mqsb_pkg::FuncW-1:0]          func_i     = mqsb_pkg::FuncEnq;
  logic [mqsb_pkg::QidW-1:0]           queue_id_i = '0;
  logic signed [mqsb_pkg::WordW-1:0]   value_i    = '0;
  logic                                busy_o;
  logic                                done_o;
  logic [mqsb_pkg::StatusW-1:0]        status_o;
  logic signed [mqsb_pkg::WordW-1:0]   data_o;

  logic signed [mqsb_pkg::WordW-1:0]   slot_word [Slots];
  ptr_t                                slot_next [Slots];
  ptr_t                                head_ptr  [Queues];
  ptr_t                                tail_ptr  [Queues];
  ptr_t                                free_ptr;

  result_t                             pending_results[$];
  int unsigned                         fail_count = 0;
  int unsigned                         idle_cycles = 0;
  bit                                  no_idle = 1'b0;

  multi_queue_shared_buffer #(
    .SLOTS  (Slots),
    .QUEUES (Queues)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .func_i     (func_i),
    .queue_id_i (queue_id_i),
    .value_i    (value_i),
    .done_o     (done_o),
    .status_o   (status_o),
    .data_o     (data_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic void reset_queue_state();
    for (int i = 0; i < Slots; i++) begin
      slot_word[i] = '0;
      slot_next[i] = ptr_t'(i + 1);
    end
    slot_next[Slots-1] = PtrNull;
    for (int i = 0; i < Queues; i++) begin
      head_ptr[i] = PtrNull;
      tail_ptr[i] = PtrNull;
    end
    free_ptr = '0;
  endfunction

  function automatic result_t serve_request(logic [mqsb_pkg::FuncW-1:0] func, qid_t qid,
                                            logic signed [mqsb_pkg::WordW-1:0] value);
    result_t     res;
    ptr_t        slot;
    int unsigned q;
    res.status = mqsb_pkg::StatusOk;
    res.data   = '0;
    q          = qid % Queues;
    if (func == mqsb_pkg::FuncEnq) begin
      slot = free_ptr;
      if (slot >= Slots) begin
        res.status = mqsb_pkg::StatusFull;
      end else begin
        free_ptr = slot_next[slot];
        if (head_ptr[q] >= Slots) begin
          head_ptr[q] = slot;
        end else if (tail_ptr[q] < Slots) begin
          slot_next[tail_ptr[q]] = slot;
        end
        slot_next[slot] = PtrNull;
        tail_ptr[q]     = slot;
        slot_word[slot] = value;
      end
    end else begin
      slot = head_ptr[q];
      if (slot >= Slots) begin
        res.status = mqsb_pkg::StatusEmpty;
      end else begin
        head_ptr[q]     = slot_next[slot];
        slot_next[slot] = free_ptr;
        free_ptr        = slot;
        res.data        = slot_word[slot];
      end
    end
    return res;
  endfunction

  task automatic send_word(logic [mqsb_pkg::FuncW-1:0] func, qid_t qid,
                           logic signed [mqsb_pkg::WordW-1:0] value);
    if (!no_idle && $urandom_range(99) < 26) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat ($urandom_range(5)) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i    <= 1'b1;
    func_i     <= func;
    queue_id_i <= qid;
    value_i    <= value;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(serve_request(func, qid, value));
  endtask

  task automatic test_fill_to_full();
    logic signed [mqsb_pkg::WordW-1:0] fill [Slots];
    for (int i = 0; i < Slots; i++) fill[i] = $urandom();
    fill[0] = 32'h8000_0000;
    fill[1] = 32'h7fff_ffff;
    fill[2] = 32'h0000_0000;
    fill[3] = 32'hffff_ffff;
    fill[4] = 32'h5555_5555;
    fill[5] = 32'haaaa_aaaa;
    fill[6] = 32'h0000_0001;
    fill[7] = 32'hffff_fffe;
    for (int i = 0; i < Slots; i++) send_word(mqsb_pkg::FuncEnq, qid_t'(i % Queues), fill[i]);
    send_word(mqsb_pkg::FuncEnq, qid_t'(Queues - 1), $urandom());
  endtask

  task automatic test_drain_to_empty();
    for (int i = 0; i < Slots / Queues; i++) send_word(mqsb_pkg::FuncDeq, '0, $urandom());
    send_word(mqsb_pkg::FuncDeq, '0, $urandom());
  endtask

  task automatic test_reuse_after_empty();
    send_word(mqsb_pkg::FuncEnq, '0, $urandom());
    send_word(mqsb_pkg::FuncDeq, '0, $urandom());
    send_word(mqsb_pkg::FuncDeq, '0, $urandom());
  endtask

  task automatic test_random_traffic();
    int unsigned                enq_pct;
    int unsigned                hot_q;
    bit                         focus;
    qid_t                       qid;
    logic [mqsb_pkg::FuncW-1:0] func;
    enq_pct = 50;
    hot_q   = 0;
    focus   = 1'b0;
    for (int n = 0; n < RandWords; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(3))
          0: enq_pct = 25;
          1: enq_pct = 50;
          2: enq_pct = 75;
          default: enq_pct = 95;
        endcase
        focus = 1'($urandom_range(1));
        hot_q = $urandom_range(Queues - 1);
      end
      no_idle = (n >= 600 && n < 1000);
      func = ($urandom_range(99) < enq_pct) ? mqsb_pkg::FuncEnq : mqsb_pkg::FuncDeq;
      if (focus && $urandom_range(99) < 70) qid = qid_t'(hot_q);
      else qid = qid_t'($urandom_range((1 << mqsb_pkg::QidW) - 1));
      send_word(func, qid, $urandom());
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d data %0d", status_o, data_o);
        fail_count++;
      end else begin
        result_t want;
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fail_count++;
        end
        if (data_o !== want.data) begin
          $error("data: expected %0d, got %0d", want.data, data_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("multi_queue_shared_buffer test failed");
        $finish;
      end
    end
  end

  initial begin
    reset_queue_state();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_fill_to_full();
    test_drain_to_empty();
    test_reuse_after_empty();
    test_random_traffic();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("results still outstanding: %0d", pending_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("multi_queue_shared_buffer test passed");
    end else begin
      $display("multi_queue_shared_buffer test failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/mqsb_pkg.sv
rtl/mqsb_slot_store.sv
rtl/mqsb_queue_table.sv
rtl/multi_queue_shared_buffer.sv
rtl/mqsb_checker.sv
dv/tb.sv
